/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// Steering classifier package
// Constants, stage payload types and the hash and remainder helpers shared by
// the classifier pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int MAX_QUEUES_DEF = 16;
    localparam int QUEUE_LIMIT    = 16;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;

    // 40-byte key, byte 0 in the top bits
    localparam logic [319:0] HASH_KEY = 320'h6d5a56da_255b0ec2_4167253d_43a38fb0_d0ca2bcb_ae7b30b4_77cb2da3_8030f20c_6a42b73b_beac01fa;

    localparam int          CFG_IDX_W       = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ROUTE_SLOW  = 2'd0,
        ROUTE_LOCAL = 2'd1,
        ROUTE_QUEUE = 2'd2
    } t_route;

    typedef struct packed {
        logic        slow;
        logic        is_local;
        logic [31:0] dst;
    } t_meta;

    typedef struct packed {
        t_meta        meta;
        logic [127:0] tuple;
    } t_tuple_stage;

    typedef struct packed {
        t_meta       meta;
        logic [31:0] part_hi;
        logic [31:0] part_lo;
    } t_part_stage;

    typedef struct packed {
        t_meta       meta;
        logic [31:0] hash;
        logic [3:0]  rem;
    } t_mod_stage;

    // Toeplitz contribution of 64 tuple bits starting at bit offset base
    function automatic logic [31:0] toeplitz_part(input logic [63:0] bits,
                                                  input int unsigned base);
        logic [31:0] acc;
        acc = '0;
        for (int p = 0; p < 64; p++) begin
            if (bits[63-p]) begin
                acc = acc ^ HASH_KEY[(319 - int'(base) - p) -: 32];
            end
        end
        return acc;
    endfunction

    // Eight restoring remainder steps, dividend bits MSB first
    function automatic logic [3:0] mod_step8(input logic [3:0] rem,
                                             input logic [7:0] bits,
                                             input logic [4:0] cnt);
        logic [4:0] t;
        logic [3:0] r;
        r = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= cnt) begin
                t = t - cnt;
            end
            r = t[3:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/stc_in_if.sv */
// ----------------------------------------------------------------------------
// Header request channel
// Valid/ready channel carrying the extracted header fields of one frame.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_type;
    logic [15:0] arp_oper;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [7:0]  protocol;
    logic [15:0] source_port;
    logic [15:0] target_port;

    modport source(output valid, frame_type, arp_oper, source_address,
                   target_address, protocol, source_port, target_port,
                   input ready);
    modport sink(input valid, frame_type, arp_oper, source_address,
                 target_address, protocol, source_port, target_port,
                 output ready);
endinterface

/* hw/rtl/stc_out_if.sv */
// ----------------------------------------------------------------------------
// Steering decision channel
// Valid/ready channel carrying one routing decision per frame.
// ----------------------------------------------------------------------------
interface stc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  route;
    logic [3:0]  queue_index;
    logic [31:0] lookup_address;
    logic [31:0] flow_hash;

    modport source(output valid, route, queue_index, lookup_address, flow_hash,
                   input ready);
    modport sink(input valid, route, queue_index, lookup_address, flow_hash,
                 output ready);
endinterface

/* hw/rtl/stc_tuple.sv */
// ----------------------------------------------------------------------------
// Tuple stage
// Builds the 16-byte flow tuple and the slow-path and local-subnet flags.
// ----------------------------------------------------------------------------
module stc_tuple (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_local_addr,
    stc_in_if.sink               i_in,
    output logic                 o_valid,
    output stc_pkg::t_tuple_stage o_data,
    input  logic                 i_ready
);
    logic                  r_valid;
    stc_pkg::t_tuple_stage r_data;
    stc_pkg::t_tuple_stage n_data;
    logic                  is_ipv4;
    logic                  is_arp;
    logic                  use_ports;
    logic [31:0]           src;
    logic [31:0]           dst;
    logic [15:0]           sport;
    logic [15:0]           dport;
    logic [7:0]            proto;

    always_comb begin
        is_ipv4   = (i_in.frame_type == stc_pkg::ETH_IPV4);
        is_arp    = (i_in.frame_type == stc_pkg::ETH_ARP);
        use_ports = is_ipv4 && ((i_in.protocol == stc_pkg::PROTO_TCP) ||
                                (i_in.protocol == stc_pkg::PROTO_UDP));
        src   = (is_ipv4 || is_arp) ? i_in.source_address : '0;
        dst   = (is_ipv4 || is_arp) ? i_in.target_address : '0;
        sport = use_ports ? i_in.source_port : '0;
        dport = use_ports ? i_in.target_port : '0;
        proto = is_ipv4 ? i_in.protocol : '0;

        n_data.tuple         = {src, dst, sport, dport, 24'h0, proto};
        n_data.meta.dst      = dst;
        n_data.meta.slow     = is_arp && (i_in.arp_oper == stc_pkg::ARP_REQUEST) &&
                               (i_in.target_address == i_local_addr);
        n_data.meta.is_local = ((dst & stc_pkg::SUBNET_MASK) ==
                                (i_local_addr & stc_pkg::SUBNET_MASK));
    end

    assign i_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/stc_hash.sv */
// ----------------------------------------------------------------------------
// Toeplitz hash stages
// Two register stages: two 64-bit halves of the tuple are hashed in parallel,
// then the halves are folded into the 32-bit flow hash.
// ----------------------------------------------------------------------------
module stc_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  stc_pkg::t_tuple_stage i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output stc_pkg::t_mod_stage   o_data,
    input  logic                  i_ready
);
    logic                 r_part_valid;
    stc_pkg::t_part_stage r_part;
    stc_pkg::t_part_stage n_part;
    logic                 r_valid;
    stc_pkg::t_mod_stage  r_data;
    stc_pkg::t_mod_stage  n_data;
    logic                 fold_ready;

    always_comb begin
        n_part.meta    = i_data.meta;
        n_part.part_hi = stc_pkg::toeplitz_part(i_data.tuple[127:64], 0);
        n_part.part_lo = stc_pkg::toeplitz_part(i_data.tuple[63:0], 64);
    end

    always_comb begin
        n_data.meta = r_part.meta;
        n_data.hash = r_part.part_hi ^ r_part.part_lo;
        n_data.rem  = '0;
    end

    assign fold_ready = !r_valid || i_ready;
    assign o_ready    = !r_part_valid || fold_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_part_valid <= i_valid;
            end
            if (fold_ready) begin
                r_valid <= r_part_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_part <= n_part;
        end
        if (fold_ready && r_part_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/stc_mod.sv */
// ----------------------------------------------------------------------------
// Queue remainder stage
// Advances the hash-modulo-queue-count remainder by one byte of the hash.
// ----------------------------------------------------------------------------
module stc_mod #(
    parameter int BYTE_SEL = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_count,
    input  logic                i_valid,
    input  stc_pkg::t_mod_stage i_data,
    output logic                o_ready,
    output logic                o_valid,
    output stc_pkg::t_mod_stage o_data,
    input  logic                i_ready
);
    logic                r_valid;
    stc_pkg::t_mod_stage r_data;
    stc_pkg::t_mod_stage n_data;

    always_comb begin
        n_data     = i_data;
        n_data.rem = stc_pkg::mod_step8(i_data.rem, i_data.hash[8*BYTE_SEL +: 8], i_count);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* hw/rtl/packet_steer_toeplitz_classifier.sv */
// Each request passes the tuple, part, fold and four remainder registers.
// Throughput: one request per cycle; each stage holds its request while the
// next is full, so the rate is set only by the output ready.
// The queue remainder takes four of the seven stages, one hash byte each.
// Reset clears all stage valid bits, local_address to 0 and queue_count to 1.
// ----------------------------------------------------------------------------
// Packet steering classifier
// Routes each frame to the ARP slow path, the local subnet, or a transmit
// queue picked by a Toeplitz flow hash modulo the queue count.
// ----------------------------------------------------------------------------
module packet_steer_toeplitz_classifier #(
    parameter int MAX_QUEUES = stc_pkg::MAX_QUEUES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    stc_in_if.sink                        i_in,
    stc_out_if.source                     o_out
);
    localparam int CAP_INT = (MAX_QUEUES < stc_pkg::QUEUE_LIMIT) ? MAX_QUEUES
                                                                 : stc_pkg::QUEUE_LIMIT;
    localparam logic [4:0] COUNT_CAP = 5'(CAP_INT);

    logic [31:0] r_local_addr;
    logic [4:0]  r_queue_count;
    logic [4:0]  n_queue_count;

    logic                  tup_valid;
    logic                  tup_ready;
    stc_pkg::t_tuple_stage tup_data;

    logic                mod_valid [0:4];
    logic                mod_ready [0:4];
    stc_pkg::t_mod_stage mod_data  [0:4];

    stc_pkg::t_mod_stage last;

    // Clamp the queue count once, at write time
    always_comb begin
        if (i_cfg_data[4:0] == 5'd0) begin
            n_queue_count = 5'd1;
        end else if (i_cfg_data[4:0] > COUNT_CAP) begin
            n_queue_count = COUNT_CAP;
        end else begin
            n_queue_count = i_cfg_data[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr  <= '0;
            r_queue_count <= 5'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == stc_pkg::CFG_LOCAL_ADDR) begin
                r_local_addr <= i_cfg_data;
            end else if (i_cfg_index == stc_pkg::CFG_QUEUE_COUNT) begin
                r_queue_count <= n_queue_count;
            end
        end
    end

    stc_tuple u_tuple (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_local_addr (r_local_addr),
        .i_in         (i_in),
        .o_valid      (tup_valid),
        .o_data       (tup_data),
        .i_ready      (tup_ready)
    );

    stc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tup_valid),
        .i_data  (tup_data),
        .o_ready (tup_ready),
        .o_valid (mod_valid[0]),
        .o_data  (mod_data[0]),
        .i_ready (mod_ready[0])
    );

    // Remainder over the hash, top byte first
    for (genvar g = 0; g < 4; g++) begin : g_mod
        stc_mod #(
            .BYTE_SEL (3 - g)
        ) u_mod (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_queue_count),
            .i_valid (mod_valid[g]),
            .i_data  (mod_data[g]),
            .o_ready (mod_ready[g]),
            .o_valid (mod_valid[g+1]),
            .o_data  (mod_data[g+1]),
            .i_ready (mod_ready[g+1])
        );
    end

    assign last         = mod_data[4];
    assign mod_ready[4] = o_out.ready;
    assign o_out.valid  = mod_valid[4];

    always_comb begin
        if (last.meta.slow) begin
            o_out.route          = stc_pkg::ROUTE_SLOW;
            o_out.queue_index    = '0;
            o_out.lookup_address = '0;
            o_out.flow_hash      = '0;
        end else if (last.meta.is_local) begin
            o_out.route          = stc_pkg::ROUTE_LOCAL;
            o_out.queue_index    = '0;
            o_out.lookup_address = last.meta.dst;
            o_out.flow_hash      = last.hash;
        end else begin
            o_out.route          = stc_pkg::ROUTE_QUEUE;
            o_out.queue_index    = last.rem;
            o_out.lookup_address = '0;
            o_out.flow_hash      = last.hash;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_queue_count != 5'd0) && (r_queue_count <= COUNT_CAP))
        else $error("queue count register out of range");

    a_queue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.route == stc_pkg::ROUTE_QUEUE))
        |-> ({1'b0, o_out.queue_index} < r_queue_count))
        else $error("queue index not below queue count");

    a_reset_count: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_queue_count == 5'd1) && (r_local_addr == 32'd0)
                            && !o_out.valid)
        else $error("configuration or output valid not cleared by reset");
`endif

endmodule

/* sim/packet_steer_toeplitz_classifier_tb.sv */
// ----------------------------------------------------------------------------
// Steering classifier testbench
// Sends header requests through a directed table and then through random phases
// under several register settings. Each decision is checked against its table row
// or a local Toeplitz/steering predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module packet_steer_toeplitz_classifier_tb;

    localparam int ITEMS_PER_PHASE = 154;
    localparam int PHASES          = 8;
    localparam int IDLE_LIMIT      = 1000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int MAX_PRINTS      = 40;

    // Indexes past the register file; writes there must change nothing
    localparam logic [stc_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [stc_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Flow hash key, byte 0 in the top bits
    localparam logic [319:0] RSS_KEY = {
        32'h6d5a56da, 32'h255b0ec2, 32'h4167253d, 32'h43a38fb0, 32'hd0ca2bcb,
        32'hae7b30b4, 32'h77cb2da3, 32'h8030f20c, 32'h6a42b73b, 32'hbeac01fa};

    localparam logic [31:0] QUEUE_SETTINGS [PHASES] = '{
        32'd16, 32'd0, 32'd17, 32'd31, 32'hFFFF_FFE3, 32'd5, 32'd1, 32'd16};

    typedef struct packed {
        logic [15:0] frame_type;
        logic [15:0] arp_oper;
        logic [31:0] source_address;
        logic [31:0] target_address;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] target_port;
    } t_header;

    typedef struct packed {
        stc_pkg::t_route route;
        logic [3:0]      queue_index;
        logic [31:0]     lookup_address;
        logic [31:0]     flow_hash;
    } t_decision;

    typedef struct packed {
        t_header   hdr;
        logic      known;
        t_decision want;
    } t_vector;

    localparam t_decision SLOW_ZERO  = '{stc_pkg::ROUTE_SLOW, 4'd0, 32'd0, 32'd0};
    localparam t_decision LOCAL_ZERO = '{stc_pkg::ROUTE_LOCAL, 4'd0, 32'd0, 32'd0};

    localparam int DIR_N = 21;
    // Rows run with reset settings: local address 0, one queue
    localparam t_vector DIRECTED [DIR_N] = '{
        // ARP request for our own address
        '{'{stc_pkg::ETH_ARP, stc_pkg::ARP_REQUEST, 32'hFFFF_FFFF, 32'h0000_0000,
            8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, SLOW_ZERO},
        '{'{stc_pkg::ETH_ARP, stc_pkg::ARP_REQUEST, 32'h0000_0000, 32'h0000_0000,
            8'h00, 16'h0000, 16'h0000}, 1'b1, SLOW_ZERO},
        // unknown ether types and an all-zero IPv4 header give a zero tuple: local, zero hash
        '{'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            8'hFF, 16'hFFFF, 16'hFFFF}, 1'b1, LOCAL_ZERO},
        '{'{16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000,
            8'h00, 16'h0000, 16'h0000}, 1'b1, LOCAL_ZERO},
        '{'{16'h0801, stc_pkg::ARP_REQUEST, 32'hA5A5_5A5A, 32'h1234_5678,
            stc_pkg::PROTO_TCP, 16'h1234, 16'h5678}, 1'b1, LOCAL_ZERO},
        '{'{16'h0807, stc_pkg::ARP_REQUEST, 32'h0102_0304, 32'h0000_0000,
            stc_pkg::PROTO_UDP, 16'h0050, 16'h01BB}, 1'b1, LOCAL_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0000_0000, 32'h0000_0000,
            8'h00, 16'h0000, 16'h0000}, 1'b1, LOCAL_ZERO},
        // ARP reply to our address is not the slow path
        '{'{stc_pkg::ETH_ARP, 16'h0002, 32'h0A00_0001, 32'h0000_0000,
            stc_pkg::PROTO_TCP, 16'h1111, 16'h2222}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_ARP, 16'hFFFF, 32'hFFFF_FFFF, 32'h1234_5678,
            8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_ARP, stc_pkg::ARP_REQUEST, 32'h0A0B_0C0D, 32'h0000_00FF,
            8'h11, 16'h0001, 16'h0002}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_ARP, stc_pkg::ARP_REQUEST, 32'h0A0B_0C0D, 32'h0000_0100,
            8'h06, 16'h8000, 16'h0001}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0A00_0001, 32'h0A00_0102,
            stc_pkg::PROTO_TCP, 16'h3039, 16'h0050}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            stc_pkg::PROTO_UDP, 16'hFFFF, 16'hFFFF}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0001, 32'h1357_9BDF, 32'h2468_ACE0,
            8'h00, 16'hFFFF, 16'hFFFF}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0A01_0203, 32'h0B04_0506,
            8'd5, 16'h1234, 16'h4321}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0A01_0203, 32'h0B04_0506,
            8'd7, 16'h1234, 16'h4321}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0A01_0203, 32'h0B04_0506,
            8'd16, 16'h1234, 16'h4321}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0A01_0203, 32'h0B04_0506,
            8'd18, 16'h1234, 16'h4321}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h0000_0000, 32'h8000_0000,
            stc_pkg::PROTO_TCP, 16'h8000, 16'h0001}, 1'b0, SLOW_ZERO},
        '{'{stc_pkg::ETH_IPV4, 16'h0000, 32'h8000_0000, 32'h0000_0001,
            stc_pkg::PROTO_UDP, 16'h0001, 16'h8000}, 1'b0, SLOW_ZERO}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [stc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;

    stc_in_if  in_if ();
    stc_out_if out_if ();

    packet_steer_toeplitz_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor copy of the register file
    logic [31:0] local_addr_q;
    logic [4:0]  queue_count_q;

    t_decision   pending_decisions [$];
    logic        req_known;
    t_decision   req_want;
    bit          quiet;
    int          errors;
    int          requests_sent;
    int          decisions_checked;
    int          route_seen [3];
    int          idle_cycles;
    int          stall_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] toeplitz_hash(input logic [127:0] tuple);
        logic [31:0] acc;
        acc = '0;
        for (int p = 0; p < 128; p++) begin
            if (tuple[127-p]) begin
                acc = acc ^ RSS_KEY[319-p -: 32];
            end
        end
        return acc;
    endfunction

    function automatic t_decision steer_predict(input t_header h);
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ports;
        logic [31:0] proto;
        int unsigned nq;
        t_decision   d;
        src   = '0;
        dst   = '0;
        ports = '0;
        proto = '0;
        d     = SLOW_ZERO;
        if (h.frame_type == stc_pkg::ETH_ARP && h.arp_oper == stc_pkg::ARP_REQUEST &&
            h.target_address == local_addr_q) begin
            return d;
        end
        if (h.frame_type == stc_pkg::ETH_IPV4) begin
            src   = h.source_address;
            dst   = h.target_address;
            proto = {24'd0, h.protocol};
            if (h.protocol == stc_pkg::PROTO_TCP || h.protocol == stc_pkg::PROTO_UDP) begin
                ports = {h.source_port, h.target_port};
            end
        end else if (h.frame_type == stc_pkg::ETH_ARP) begin
            src = h.source_address;
            dst = h.target_address;
        end
        d.flow_hash = toeplitz_hash({src, dst, ports, proto});
        if ((dst & stc_pkg::SUBNET_MASK) == (local_addr_q & stc_pkg::SUBNET_MASK)) begin
            d.route          = stc_pkg::ROUTE_LOCAL;
            d.lookup_address = dst;
        end else begin
            nq = queue_count_q;
            if (nq == 0) nq = 1;
            if (nq > stc_pkg::MAX_QUEUES_DEF) nq = stc_pkg::MAX_QUEUES_DEF;
            if (nq > stc_pkg::QUEUE_LIMIT) nq = stc_pkg::QUEUE_LIMIT;
            d.route       = stc_pkg::ROUTE_QUEUE;
            d.queue_index = 4'(d.flow_hash % nq);
        end
        return d;
    endfunction

    // Mostly well-formed IPv4/ARP traffic aimed near the local address
    function automatic t_header random_header();
        t_header     h;
        int unsigned pick;
        h.frame_type     = 16'($urandom());
        h.arp_oper       = 16'($urandom());
        h.source_address = $urandom();
        h.target_address = $urandom();
        h.protocol       = 8'($urandom());
        h.source_port    = 16'($urandom());
        h.target_port    = 16'($urandom());
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            h.frame_type = stc_pkg::ETH_IPV4;
        end else if (pick < 7) begin
            h.frame_type = stc_pkg::ETH_ARP;
        end else if (pick == 7) begin
            h.frame_type = stc_pkg::ETH_IPV4 ^ (16'd1 << $urandom_range(0, 15));
        end
        if ($urandom_range(0, 1) == 0) begin
            h.arp_oper = stc_pkg::ARP_REQUEST;
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            h.target_address = local_addr_q;
        end else if (pick < 6) begin
            h.target_address = {local_addr_q[31:8], 8'($urandom())};
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            h.protocol = stc_pkg::PROTO_TCP;
        end else if (pick < 6) begin
            h.protocol = stc_pkg::PROTO_UDP;
        end
        return h;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < MAX_PRINTS) begin
            $display("ERROR decision %0d %s: got %h, want %h",
                     decisions_checked, what, got, want);
        end
        errors++;
    endtask

    task automatic write_reg(input logic [stc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        if (idx == stc_pkg::CFG_LOCAL_ADDR) begin
            local_addr_q = data;
        end else if (idx == stc_pkg::CFG_QUEUE_COUNT) begin
            queue_count_q = data[4:0];
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_header(input t_header h, input logic known, input t_decision want);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.frame_type     <= h.frame_type;
        in_if.arp_oper       <= h.arp_oper;
        in_if.source_address <= h.source_address;
        in_if.target_address <= h.target_address;
        in_if.protocol       <= h.protocol;
        in_if.source_port    <= h.source_port;
        in_if.target_port    <= h.target_port;
        req_known            <= known;
        req_want             <= want;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic settle();
        // let the monitor log the request accepted at this edge
        @(posedge i_clk);
        while (pending_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output stalls in random bursts; no new burst starts while quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_header   hdr;
        t_decision want;
        if (in_if.valid && in_if.ready) begin
            hdr = '{in_if.frame_type, in_if.arp_oper, in_if.source_address,
                    in_if.target_address, in_if.protocol, in_if.source_port,
                    in_if.target_port};
            pending_decisions.push_back(req_known ? req_want : steer_predict(hdr));
            requests_sent++;
        end
        if (out_if.valid && out_if.ready) begin
            if (pending_decisions.size() == 0) begin
                flag_mismatch("unexpected decision", {30'd0, out_if.route}, 32'd0);
            end else begin
                want = pending_decisions.pop_front();
                if (out_if.route != want.route)
                    flag_mismatch("route", {30'd0, out_if.route}, {30'd0, want.route});
                if (out_if.queue_index != want.queue_index)
                    flag_mismatch("queue_index", {28'd0, out_if.queue_index},
                                  {28'd0, want.queue_index});
                if (out_if.lookup_address != want.lookup_address)
                    flag_mismatch("lookup_address", out_if.lookup_address,
                                  want.lookup_address);
                if (out_if.flow_hash != want.flow_hash)
                    flag_mismatch("flow_hash", out_if.flow_hash, want.flow_hash);
                route_seen[int'(want.route)]++;
            end
            decisions_checked++;
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        local_addr_q         = 32'd0;
        queue_count_q        = 5'd1;
        quiet                = 1'b0;
        errors               = 0;
        requests_sent        = 0;
        decisions_checked    = 0;
        route_seen           = '{0, 0, 0};
        idle_cycles          = 0;
        stall_left           = 0;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= stc_pkg::CFG_LOCAL_ADDR;
        i_cfg_data           <= 32'd0;
        in_if.valid          <= 1'b0;
        in_if.frame_type     <= 16'd0;
        in_if.arp_oper       <= 16'd0;
        in_if.source_address <= 32'd0;
        in_if.target_address <= 32'd0;
        in_if.protocol       <= 8'd0;
        in_if.source_port    <= 16'd0;
        in_if.target_port    <= 16'd0;
        req_known            <= 1'b0;
        req_want             <= SLOW_ZERO;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            send_header(DIRECTED[i].hdr, DIRECTED[i].known, DIRECTED[i].want);
        end
        in_if.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            settle();
            // drop idling on both sides for the last phase
            quiet = (p == PHASES - 1);
            write_reg(stc_pkg::CFG_LOCAL_ADDR,
                      (p == 1) ? 32'hFFFF_FFFF : (p == 3) ? 32'd0 : $urandom());
            write_reg(stc_pkg::CFG_QUEUE_COUNT, QUEUE_SETTINGS[p]);
            write_reg(CFG_SPARE_2, $urandom());
            write_reg(CFG_SPARE_3, $urandom());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_header(random_header(), 1'b0, SLOW_ZERO);
            end
            in_if.valid <= 1'b0;
        end
        settle();

        $display("Checked %0d decisions for %0d requests across %0d register settings",
                 decisions_checked, requests_sent, PHASES + 1);
        $display("Routes: %0d slow path, %0d local subnet, %0d transmit queue",
                 route_seen[0], route_seen[1], route_seen[2]);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/stc_pkg.sv
hw/rtl/stc_in_if.sv
hw/rtl/stc_out_if.sv
hw/rtl/stc_tuple.sv
hw/rtl/stc_hash.sv
hw/rtl/stc_mod.sv
hw/rtl/packet_steer_toeplitz_classifier.sv
sim/packet_steer_toeplitz_classifier_tb.sv
